// ----- hdl/mtfl_pkg.sv -----
// mtfl_pkg: shared types and constants for the move-to-front key list
// no dependencies

package mtfl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 31;
  localparam int CMD_W        = 2;
  localparam int POS_W        = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } mtfl_cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } mtfl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } mtfl_ctrl_t;

endpackage

// ----- hdl/mtf_lru_key_list_unit.sv -----
// mtf_lru_key_list_unit: move-to-front key list, top level
// depends on mtfl_pkg, mtfl_ctrl, mtfl_dpath
//
//   channel  ports                                              dir
//   in       in_valid in_ready in_cmd in_key                    sink
//   out      out_valid out_ready out_hit out_hit_position       source
//            out_evicted_valid out_evicted_key out_entries
//
// each word is compared against all cells into a match register when it is
// accepted; the update state then shifts the cells and loads the result register
// a new word is taken while a result still waits; the update cycle holds
// until the result register is free
// synchronous active-low reset empties the list, cell contents are not cleared

module mtf_lru_key_list_unit import mtfl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit,
  output logic [POS_W-1:0] out_hit_position,
  output logic             out_evicted_valid,
  output logic [KEY_W-1:0] out_evicted_key,
  output logic [POS_W-1:0] out_entries
);

  mtfl_ctrl_t ctrl;

  mtfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  mtfl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_cmd            (in_cmd),
    .in_key            (in_key),
    .out_hit           (out_hit),
    .out_hit_position  (out_hit_position),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_entries       (out_entries)
  );

endmodule

// ----- hdl/mtfl_ctrl.sv -----
// mtfl_ctrl: two-state sequencer and result valid flag
// depends on mtfl_pkg

module mtfl_ctrl import mtfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output mtfl_ctrl_t ctrl
);

  mtfl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      ST_UPDATE: begin
        // result register must be free or draining this cycle
        ctrl.commit = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_capture_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.capture |=> state_r == ST_UPDATE)
    else $error("capture did not move to update");

  a_hold_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && out_valid_r && !out_ready) |=> state_r == ST_UPDATE)
    else $error("update left while result register was full");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> out_valid_r)
    else $error("commit did not raise result valid");
`endif

endmodule

// ----- hdl/mtfl_dpath.sv -----
// mtfl_dpath: key cells, parallel match register, length counter, result register
// depends on mtfl_pkg

module mtfl_dpath import mtfl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mtfl_ctrl_t       ctrl,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_hit,
  output logic [POS_W-1:0] out_hit_position,
  output logic             out_evicted_valid,
  output logic [KEY_W-1:0] out_evicted_key,
  output logic [POS_W-1:0] out_entries
);

  localparam int SLOTS = CAPACITY + 1;
  localparam int LEN_W = $clog2(SLOTS + 1);
  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(SLOTS);

  logic [KEY_W-1:0] keys_r   [SLOTS];
  logic [KEY_W-1:0] keys_nxt [SLOTS];
  logic [LEN_W-1:0] len_r, len_nxt;
  mtfl_cmd_t        cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [SLOTS-1:0] match_r;

  logic [SLOTS-1:0] ahead;
  logic             hit;
  logic [IDX_W-1:0] pos;
  logic             full;
  logic             ev_valid;

  // compare all live cells against the incoming word at accept
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= mtfl_cmd_t'(in_cmd);
      key_r <= in_key;
      for (int i = 0; i < SLOTS; i++) begin
        match_r[i] <= (keys_r[i] == in_key) && (LEN_W'(i) < len_r);
      end
    end
  end

  // ahead[i]: some match sits ahead of cell i
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      ahead[i] = acc;
      acc      = acc | match_r[i];
    end
    hit = acc;
  end

  always_comb begin
    pos = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) pos = IDX_W'(i);
    end
  end

  assign full     = (len_r == LEN_FULL);
  assign ev_valid = (cmd_r == CMD_GET) && !hit && full;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      keys_nxt[i] = keys_r[i];
    end
    len_nxt = len_r;
    case (cmd_r)
      CMD_CLEAR: begin
        len_nxt = '0;
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int i = 0; i < SLOTS - 1; i++) begin
            if (ahead[i] || match_r[i]) keys_nxt[i] = keys_r[i+1];
          end
          len_nxt = len_r - LEN_W'(1);
        end
      end
      CMD_GET, CMD_FIND: begin
        if (hit) begin
          // cells up to the hit slide back one, the key goes to the front
          for (int i = 1; i < SLOTS; i++) begin
            if (!ahead[i]) keys_nxt[i] = keys_r[i-1];
          end
          keys_nxt[0] = key_r;
        end else if (cmd_r == CMD_GET) begin
          // insert at front, the tail cell falls off when full
          for (int i = 1; i < SLOTS; i++) begin
            keys_nxt[i] = keys_r[i-1];
          end
          keys_nxt[0] = key_r;
          if (!full) len_nxt = len_r + LEN_W'(1);
        end
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      for (int i = 0; i < SLOTS; i++) begin
        keys_r[i] <= keys_nxt[i];
      end
      out_hit           <= hit && (cmd_r != CMD_CLEAR);
      out_hit_position  <= (hit && (cmd_r != CMD_CLEAR)) ? POS_W'(pos) : '0;
      out_evicted_valid <= ev_valid;
      out_evicted_key   <= ev_valid ? keys_r[SLOTS-1] : '0;
      out_entries       <= POS_W'(len_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (ctrl.commit) begin
      len_r <= len_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("list length beyond slot count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.commit && cmd_r == CMD_CLEAR) |=> len_r == '0)
    else $error("clear left entries behind");

  a_hit_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.commit && hit) |=> len_r <= $past(len_r))
    else $error("list grew on a hit");
`endif

endmodule

// ----- dv/tb.sv -----
// tb: self-checking testbench for mtf_lru_key_list_unit, the move-to-front key list
// a directed table and then random command words; each result is checked against the table's word or a shadow list
// depends on mtfl_pkg and mtf_lru_key_list_unit

module tb;
  import mtfl_pkg::*;

  localparam int CAP    = CAPACITY_DEF;
  localparam int SLOTS  = CAP + 1;
  localparam int N_RAND = 1620;
  localparam int POOL_N = 24;
  localparam int IDLE_PCT = 18;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
    logic             ev;
    logic [KEY_W-1:0] ev_key;
    logic [POS_W-1:0] ent;
  } lru_res_t;

  typedef struct {
    mtfl_cmd_t        cmd;
    logic [KEY_W-1:0] key;
    int               reps;
    bit               typed;
    lru_res_t         want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [KEY_W-1:0] in_key;
  logic             out_valid;
  logic             out_ready;
  logic             out_hit;
  logic [POS_W-1:0] out_hit_position;
  logic             out_evicted_valid;
  logic [KEY_W-1:0] out_evicted_key;
  logic [POS_W-1:0] out_entries;

  logic [KEY_W-1:0] shadow_keys [SLOTS];
  int               shadow_len;
  lru_res_t         due_results [$];
  logic [KEY_W-1:0] key_pool [POOL_N];
  bit               calm = 1'b0;
  int               err_cnt = 0;
  int               words_seen = 0;

  // after reset the list is empty; rows with typed=0 take the shadow list's answer
  localparam int N_DIR = 15;
  dir_row_t dir_tab [N_DIR] = '{
    '{CMD_GET,    31'h0000_0000, 1,  1'b1, '{1'b0, 5'd0, 1'b0, 31'h0, 5'd1}},
    '{CMD_GET,    31'h7fff_ffff, 1,  1'b1, '{1'b0, 5'd0, 1'b0, 31'h0, 5'd2}},
    '{CMD_GET,    31'h0000_0000, 1,  1'b1, '{1'b1, 5'd1, 1'b0, 31'h0, 5'd2}},
    '{CMD_FIND,   31'h7fff_ffff, 1,  1'b1, '{1'b1, 5'd1, 1'b0, 31'h0, 5'd2}},
    '{CMD_FIND,   31'h0000_0005, 1,  1'b1, '{1'b0, 5'd0, 1'b0, 31'h0, 5'd2}},
    '{CMD_REMOVE, 31'h0000_0005, 1,  1'b1, '{1'b0, 5'd0, 1'b0, 31'h0, 5'd2}},
    '{CMD_REMOVE, 31'h0000_0000, 1,  1'b1, '{1'b1, 5'd1, 1'b0, 31'h0, 5'd1}},
    '{CMD_CLEAR,  31'h5555_5555, 1,  1'b1, '{1'b0, 5'd0, 1'b0, 31'h0, 5'd0}},
    '{CMD_REMOVE, 31'h7fff_ffff, 1,  1'b1, '{1'b0, 5'd0, 1'b0, 31'h0, 5'd0}},
    // fill to capacity plus one, then force a tail drop
    '{CMD_GET,    31'h0000_0100, 17, 1'b0, '0},
    '{CMD_GET,    31'h4000_0000, 1,  1'b1, '{1'b0, 5'd0, 1'b1, 31'h100, 5'd17}},
    '{CMD_FIND,   31'h0000_0101, 1,  1'b0, '0},
    '{CMD_GET,    31'h2aaa_aaaa, 1,  1'b0, '0},
    '{CMD_REMOVE, 31'h0000_0110, 1,  1'b0, '0},
    '{CMD_CLEAR,  31'h0000_0000, 1,  1'b1, '0}
  };

  mtf_lru_key_list_unit #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_hit_position (out_hit_position),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_key  (out_evicted_key),
    .out_entries      (out_entries)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one command to the shadow list and returns the result word it gives
  function automatic lru_res_t mtf_update(mtfl_cmd_t c, logic [KEY_W-1:0] k);
    lru_res_t r;
    int       p;
    bit       found;
    r = '0;
    p = 0;
    found = 1'b0;
    if (c == CMD_CLEAR) begin
      shadow_len = 0;
    end else begin
      for (int i = 0; i < shadow_len; i++) begin
        if (!found && shadow_keys[i] == k) begin
          found = 1'b1;
          p = i;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.pos = POS_W'(p);
        if (c == CMD_REMOVE) begin
          for (int i = p; i < shadow_len - 1; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_len--;
        end else begin
          for (int i = p; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[0] = k;
        end
      end else if (c == CMD_GET) begin
        // a full list sheds its tail before the new key goes in front
        if (shadow_len > CAP) begin
          r.ev     = 1'b1;
          r.ev_key = shadow_keys[CAP];
          shadow_len = CAP;
        end
        for (int i = shadow_len; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[0] = k;
        shadow_len++;
      end
    end
    r.ent = POS_W'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic send_word(mtfl_cmd_t c, logic [KEY_W-1:0] k, bit typed, lru_res_t want);
    lru_res_t pred;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_key   <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = mtf_update(c, k);
    due_results.push_back(typed ? want : pred);
  endtask

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    lru_res_t got;
    lru_res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_hit, out_hit_position, out_evicted_valid, out_evicted_key, out_entries};
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing expected", words_seen));
      end else begin
        want = due_results.pop_front();
        if (got.hit !== want.hit)
          report_mismatch($sformatf("word %0d hit %0b want %0b", words_seen, got.hit, want.hit));
        if (got.pos !== want.pos)
          report_mismatch($sformatf("word %0d hit_position %0d want %0d",
                                    words_seen, got.pos, want.pos));
        if (got.ev !== want.ev)
          report_mismatch($sformatf("word %0d evicted_valid %0b want %0b",
                                    words_seen, got.ev, want.ev));
        if (got.ev_key !== want.ev_key)
          report_mismatch($sformatf("word %0d evicted_key %h want %h",
                                    words_seen, got.ev_key, want.ev_key));
        if (got.ent !== want.ent)
          report_mismatch($sformatf("word %0d entries %0d want %0d",
                                    words_seen, got.ent, want.ent));
      end
      words_seen++;
    end
  end

  initial begin : stim
    mtfl_cmd_t        c;
    logic [KEY_W-1:0] k;
    int               sel;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = CMD_GET;
    in_key    = '0;
    out_ready = 1'b0;
    shadow_len = 0;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = KEY_W'($urandom());
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      for (int n = 0; n < dir_tab[r].reps; n++)
        send_word(dir_tab[r].cmd, dir_tab[r].key + KEY_W'(n), dir_tab[r].typed,
                  dir_tab[r].want);
    end

    // a small key pool keeps the list full and hit-heavy; stray keys give misses
    for (int n = 0; n < N_RAND; n++) begin
      calm = (n >= 500 && n < 850);
      sel = $urandom_range(99);
      if (sel < 55)      c = CMD_GET;
      else if (sel < 73) c = CMD_FIND;
      else if (sel < 93) c = CMD_REMOVE;
      else if (sel < 99) c = CMD_GET;
      else               c = CMD_CLEAR;
      sel = $urandom_range(99);
      if (sel < 80)
        k = key_pool[$urandom_range(POOL_N-1)];
      else if (sel < 88)
        k = key_pool[$urandom_range(POOL_N-1)] ^ (KEY_W'(1) << $urandom_range(KEY_W-1));
      else
        k = KEY_W'($urandom());
      if ($urandom_range(99) < 3) key_pool[$urandom_range(POOL_N-1)] = KEY_W'($urandom());
      send_word(c, k, 1'b0, '0);
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d result words outstanding", due_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mtfl_pkg.sv
hdl/mtfl_ctrl.sv
hdl/mtfl_dpath.sv
hdl/mtf_lru_key_list_unit.sv
dv/tb.sv
